/* sv/cpc_pkg.sv */
// shared constants, types and the arctangent table of the coordinate converter
package cpc_pkg;

  // default configuration
  localparam int unsigned ITERATIONS_DEF = 16;
  localparam int unsigned DATA_WIDTH_DEF = 16;

  // fraction bits added to the operands inside the datapath
  localparam int unsigned GUARD = 16;

  // internal angle: 32 bits per full turn plus one sign bit for rotation mode
  localparam int unsigned ANGLE_W = 32;
  localparam int unsigned ZW      = ANGLE_W + 1;

  // reciprocal of the limit gain of the rotation sequence, q30
  localparam int unsigned GAIN_W     = 30;
  localparam int unsigned GAIN_SHIFT = 30 + GUARD;
  localparam logic [GAIN_W-1:0] GAIN_Q30 = 30'h26DD3B6A;

  // operation of one beat
  typedef enum logic {
    KIND_TO_POLAR = 1'b0,
    KIND_TO_CART  = 1'b1
  } cpc_kind_e;

  // control that travels with each vector
  typedef struct packed {
    cpc_kind_e kind;
    logic      zero;
  } cpc_ctl_t;

  // round(atan(2^-i) * 2^31 / pi)
  function automatic logic [ANGLE_W-1:0] atan_lut(input logic [4:0] idx);
    logic [ANGLE_W-1:0] v;
    unique case (idx)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051E;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2FA;
      5'd15:   v = 32'h0000517D;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A30;
      5'd19:   v = 32'h00000518;
      5'd20:   v = 32'h0000028C;
      5'd21:   v = 32'h00000146;
      5'd22:   v = 32'h000000A3;
      5'd23:   v = 32'h00000051;
      5'd24:   v = 32'h00000029;
      5'd25:   v = 32'h00000014;
      5'd26:   v = 32'h0000000A;
      5'd27:   v = 32'h00000005;
      5'd28:   v = 32'h00000003;
      5'd29:   v = 32'h00000001;
      5'd30:   v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

/* sv/cpc_if.sv */
// valid/ready channels for operand beats and result beats
interface cpc_in_if #(
  parameter int unsigned DATA_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic signed [DATA_WIDTH-1:0] first_in;
  logic signed [DATA_WIDTH-1:0] second_in;

  modport source (output valid, output kind, output first_in, output second_in, input ready);
  modport sink   (input valid, input kind, input first_in, input second_in, output ready);
endinterface

interface cpc_out_if #(
  parameter int unsigned DATA_WIDTH = 16
);
  logic                       valid;
  logic                       ready;
  logic signed [DATA_WIDTH:0] first_out;
  logic signed [DATA_WIDTH:0] second_out;

  modport source (output valid, output first_out, output second_out, input ready);
  modport sink   (input valid, input first_out, input second_out, output ready);
endinterface

/* sv/cart_polar_converter.sv */
// cartesian/polar converter top level: operand prep, cordic pipeline, gain scaling
//
// Each beat converts (x, y) to (magnitude, binary angle) or (r, angle) to (x, y);
// angles span -pi..pi over the signed DATA_WIDTH range. The datapath is a fully
// unrolled cordic: one prep stage, ITERATIONS micro-rotation stages and three gain
// stages (magnitude split, partial products, combine/round/saturate into the output
// register). One beat is taken every clock cycle while the prep stage is not stalled;
// every stage holds its own valid bit, so back-pressure at the output only stalls the
// stages that are full and bubbles close up.
module cart_polar_converter
  import cpc_pkg::*;
#(
  parameter int unsigned ITERATIONS = ITERATIONS_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cpc_in_if.sink    in_i,
  cpc_out_if.source out_o
);

  localparam int unsigned DW  = DATA_WIDTH;
  localparam int unsigned W   = DW + GUARD + 3;   // datapath width with growth headroom
  localparam int unsigned M   = W - 1;            // magnitude width
  localparam int unsigned L   = (M + 1) / 2;      // low part of the split multiply
  localparam int unsigned H   = M - L;
  localparam int unsigned TW  = M + GAIN_W + 1;   // width of the recombined product
  localparam int unsigned RW  = TW - GAIN_SHIFT;  // width of the rounded magnitude
  localparam int unsigned ZSH = ANGLE_W - DW;     // internal angle to output angle

  localparam logic [ANGLE_W-1:0] ANG_HALF =
    (ZSH == 0) ? '0 : ANGLE_W'(64'd1 << (ZSH - 1));
  localparam logic signed [ZW-1:0] QUARTER   = ZW'(64'h0_4000_0000);
  localparam logic signed [ZW-1:0] HALF_TURN = ZW'(64'h0_8000_0000);
  localparam logic [TW-1:0] ROUND  = TW'(1) << (GAIN_SHIFT - 1);
  localparam logic [RW-1:0] LIM_HI = RW'((64'd1 << DW) - 64'd1);
  localparam logic [RW-1:0] LIM_LO = RW'(64'd1 << DW);

  // ------------------------------------------------------------------
  // operand prep stage
  // ------------------------------------------------------------------
  logic                 rdy_p;
  logic                 valid_p_q;
  cpc_ctl_t             ctl_p_q, ctl_p_d;
  logic signed [W-1:0]  x_p_q, y_p_q, x_p_d, y_p_d;
  logic signed [ZW-1:0] z_p_q, z_p_d;

  logic signed [W-1:0]  xa, yb;
  logic signed [ZW-1:0] zr;

  // scale operands; to polar folds the left half plane onto the right one, to cartesian folds angles beyond +-pi/2
  always_comb begin
    xa = {{(W - DW - GUARD){in_i.first_in[DW-1]}}, in_i.first_in, {GUARD{1'b0}}};
    yb = {{(W - DW - GUARD){in_i.second_in[DW-1]}}, in_i.second_in, {GUARD{1'b0}}};
    zr = $signed({{(ZW - DW){in_i.second_in[DW-1]}}, in_i.second_in}) <<< ZSH;
    ctl_p_d.kind = cpc_kind_e'(in_i.kind);
    ctl_p_d.zero = (in_i.first_in == '0) && (in_i.second_in == '0);
    if (ctl_p_d.kind == KIND_TO_POLAR) begin
      if (in_i.first_in[DW-1]) begin
        x_p_d = -xa;
        y_p_d = -yb;
        z_p_d = HALF_TURN;
      end else begin
        x_p_d = xa;
        y_p_d = yb;
        z_p_d = '0;
      end
    end else begin
      y_p_d = '0;
      if (zr > QUARTER) begin
        x_p_d = -xa;
        z_p_d = zr - HALF_TURN;
      end else if (zr < -QUARTER) begin
        x_p_d = -xa;
        z_p_d = zr + HALF_TURN;
      end else begin
        x_p_d = xa;
        z_p_d = zr;
      end
    end
  end

  logic rdy_c [ITERATIONS+1];

  assign rdy_p      = !valid_p_q || rdy_c[0];
  assign in_i.ready = rdy_p;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_p_q <= 1'b0;
    end else if (rdy_p) begin
      valid_p_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_p && in_i.valid) begin
      ctl_p_q <= ctl_p_d;
      x_p_q   <= x_p_d;
      y_p_q   <= y_p_d;
      z_p_q   <= z_p_d;
    end
  end

  // ------------------------------------------------------------------
  // cordic micro-rotation pipeline
  // ------------------------------------------------------------------
  logic                 valid_c [ITERATIONS+1];
  cpc_ctl_t             ctl_c   [ITERATIONS+1];
  logic signed [W-1:0]  x_c     [ITERATIONS+1];
  logic signed [W-1:0]  y_c     [ITERATIONS+1];
  logic signed [ZW-1:0] z_c     [ITERATIONS+1];

  assign valid_c[0] = valid_p_q;
  assign ctl_c[0]   = ctl_p_q;
  assign x_c[0]     = x_p_q;
  assign y_c[0]     = y_p_q;
  assign z_c[0]     = z_p_q;

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_iter
    cpc_stage #(
      .W     (W),
      .SHIFT (i)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_c[i]),
      .ready_o (rdy_c[i]),
      .ctl_i   (ctl_c[i]),
      .x_i     (x_c[i]),
      .y_i     (y_c[i]),
      .z_i     (z_c[i]),
      .valid_o (valid_c[i+1]),
      .ready_i (rdy_c[i+1]),
      .ctl_o   (ctl_c[i+1]),
      .x_o     (x_c[i+1]),
      .y_o     (y_c[i+1]),
      .z_o     (z_c[i+1])
    );
  end

  // ------------------------------------------------------------------
  // gain stage a: magnitudes, signs and the rounded output angle
  // ------------------------------------------------------------------
  logic                 rdy_a, rdy_b, rdy_o;
  logic                 valid_a_q;
  cpc_ctl_t             ctl_a_q;
  logic                 sx_a_q, sy_a_q;
  logic [M-1:0]         mx_a_q, my_a_q, mx_a_d, my_a_d;
  logic [DW-1:0]        ang_a_q, ang_a_d;
  logic signed [W-1:0]  xl, yl, xn, yn;
  logic [ANGLE_W-1:0]   ang_sum;

  always_comb begin
    xl      = x_c[ITERATIONS];
    yl      = y_c[ITERATIONS];
    xn      = -xl;
    yn      = -yl;
    mx_a_d  = xl[W-1] ? xn[M-1:0] : xl[M-1:0];
    my_a_d  = yl[W-1] ? yn[M-1:0] : yl[M-1:0];
    ang_sum = z_c[ITERATIONS][ANGLE_W-1:0] + ANG_HALF;
    ang_a_d = ang_sum[ANGLE_W-1:ZSH];
  end

  assign rdy_a              = !valid_a_q || rdy_b;
  assign rdy_c[ITERATIONS]  = rdy_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
    end else if (rdy_a) begin
      valid_a_q <= valid_c[ITERATIONS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && valid_c[ITERATIONS]) begin
      ctl_a_q <= ctl_c[ITERATIONS];
      sx_a_q  <= xl[W-1];
      sy_a_q  <= yl[W-1];
      mx_a_q  <= mx_a_d;
      my_a_q  <= my_a_d;
      ang_a_q <= ang_a_d;
    end
  end

  // ------------------------------------------------------------------
  // gain stage b: split partial products with the gain constant
  // ------------------------------------------------------------------
  logic                    valid_b_q;
  cpc_ctl_t                ctl_b_q;
  logic                    sx_b_q, sy_b_q;
  logic [DW-1:0]           ang_b_q;
  logic [L+GAIN_W-1:0]     pxl_b_q, pyl_b_q;
  logic [H+GAIN_W-1:0]     pxh_b_q, pyh_b_q;

  assign rdy_b = !valid_b_q || rdy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_b_q <= 1'b0;
    end else if (rdy_b) begin
      valid_b_q <= valid_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_b && valid_a_q) begin
      ctl_b_q <= ctl_a_q;
      sx_b_q  <= sx_a_q;
      sy_b_q  <= sy_a_q;
      ang_b_q <= ang_a_q;
      pxl_b_q <= (L+GAIN_W)'(mx_a_q[L-1:0]) * (L+GAIN_W)'(GAIN_Q30);
      pyl_b_q <= (L+GAIN_W)'(my_a_q[L-1:0]) * (L+GAIN_W)'(GAIN_Q30);
      pxh_b_q <= (H+GAIN_W)'(mx_a_q[M-1:L]) * (H+GAIN_W)'(GAIN_Q30);
      pyh_b_q <= (H+GAIN_W)'(my_a_q[M-1:L]) * (H+GAIN_W)'(GAIN_Q30);
    end
  end

  // ------------------------------------------------------------------
  // output stage: recombine, round, restore sign, saturate
  // ------------------------------------------------------------------
  logic                valid_o_q;
  logic signed [DW:0]  first_o_q, second_o_q, first_o_d, second_o_d;
  logic [TW-1:0]       tx, ty;
  logic [RW-1:0]       rx, ry;
  logic signed [DW:0]  sat_x, sat_y;
  logic [RW-1:0]       rxn, ryn;

  always_comb begin
    tx  = (TW'(pxh_b_q) << L) + TW'(pxl_b_q) + ROUND;
    ty  = (TW'(pyh_b_q) << L) + TW'(pyl_b_q) + ROUND;
    rx  = tx[TW-1:GAIN_SHIFT];
    ry  = ty[TW-1:GAIN_SHIFT];
    rxn = -rx;
    ryn = -ry;
    // x result
    if (!sx_b_q) begin
      sat_x = (rx > LIM_HI) ? $signed({1'b0, {DW{1'b1}}}) : $signed(rx[DW:0]);
    end else begin
      sat_x = (rx > LIM_LO) ? $signed({1'b1, {DW{1'b0}}}) : $signed(rxn[DW:0]);
    end
    // y result
    if (!sy_b_q) begin
      sat_y = (ry > LIM_HI) ? $signed({1'b0, {DW{1'b1}}}) : $signed(ry[DW:0]);
    end else begin
      sat_y = (ry > LIM_LO) ? $signed({1'b1, {DW{1'b0}}}) : $signed(ryn[DW:0]);
    end
    // select per kind
    if (ctl_b_q.kind == KIND_TO_POLAR) begin
      if (ctl_b_q.zero) begin
        first_o_d  = '0;
        second_o_d = '0;
      end else begin
        first_o_d  = sat_x;
        second_o_d = $signed({ang_b_q[DW-1], ang_b_q});
      end
    end else begin
      first_o_d  = sat_x;
      second_o_d = sat_y;
    end
  end

  assign rdy_o = !valid_o_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o_q <= 1'b0;
    end else if (rdy_o) begin
      valid_o_q <= valid_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_o && valid_b_q) begin
      first_o_q  <= first_o_d;
      second_o_q <= second_o_d;
    end
  end

  assign out_o.valid      = valid_o_q;
  assign out_o.first_out  = first_o_q;
  assign out_o.second_out = second_o_q;

endmodule

/* sv/cpc_stage.sv */
// one registered cordic micro-rotation with its own valid/ready slot
module cpc_stage
  import cpc_pkg::*;
#(
  parameter int unsigned W     = 35,
  parameter int unsigned SHIFT = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  cpc_ctl_t            ctl_i,
  input  logic signed [W-1:0] x_i,
  input  logic signed [W-1:0] y_i,
  input  logic signed [ZW-1:0] z_i,
  output logic                valid_o,
  input  logic                ready_i,
  output cpc_ctl_t            ctl_o,
  output logic signed [W-1:0] x_o,
  output logic signed [W-1:0] y_o,
  output logic signed [ZW-1:0] z_o
);

  localparam logic [ZW-1:0] TAB = ZW'(atan_lut(5'(SHIFT)));

  logic                 valid_q;
  cpc_ctl_t             ctl_q;
  logic signed [W-1:0]  x_q, y_q, x_d, y_d;
  logic signed [ZW-1:0] z_q, z_d;
  logic signed [W-1:0]  xs, ys;
  logic                 dir_a;

  // direction: vectoring drives y to zero, rotation drives z to zero
  always_comb begin
    xs    = x_i >>> SHIFT;
    ys    = y_i >>> SHIFT;
    dir_a = (ctl_i.kind == KIND_TO_POLAR) ? !y_i[W-1] : z_i[ZW-1];
    if (dir_a) begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + $signed(TAB);
    end else begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - $signed(TAB);
    end
  end

  assign ready_o = !valid_q || ready_i;

  // slot valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // slot payload
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      ctl_q <= ctl_i;
      x_q   <= x_d;
      y_q   <= y_d;
      z_q   <= z_d;
    end
  end

  assign valid_o = valid_q;
  assign ctl_o   = ctl_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;

endmodule

/* sim/tb_top.sv */
// self-checking testbench of the cartesian/polar cordic converter
module tb_top
  import cpc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STEPS        = 16;
  localparam int unsigned WIDTH        = 16;
  localparam int unsigned PIPE_LATENCY = STEPS + 4;
  localparam int unsigned DRAIN_CYCLES = 2 * PIPE_LATENCY;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned MAX_REPORTS  = 10;

  // reciprocal of the limit gain in q30 and the scaling of operands into the datapath
  localparam logic [29:0] CORDIC_GAIN = 30'h26DD3B6A;
  localparam longint      OPERAND_ONE = 64'sd65536;
  localparam longint      QUARTER_TURN = 64'sd1073741824;
  localparam longint      HALF_TURN    = 64'sd2147483648;
  localparam longint      OUT_MAX      = 64'sd65535;
  localparam longint      OUT_MIN      = -64'sd65536;

  // micro-rotation angles, 2^32 per full turn
  localparam logic [31:0] ARCTAN_STEP [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  typedef struct {
    cpc_kind_e                kind;
    logic signed [WIDTH-1:0]  a;
    logic signed [WIDTH-1:0]  b;
    logic signed [WIDTH:0]    first;
    logic signed [WIDTH:0]    second;
  } conv_beat_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  cpc_in_if  #(.DATA_WIDTH(WIDTH)) in_ch  ();
  cpc_out_if #(.DATA_WIDTH(WIDTH)) out_ch ();

  cart_polar_converter #(
    .ITERATIONS(STEPS),
    .DATA_WIDTH(WIDTH)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  conv_beat_t awaited_beats[$];
  int unsigned mismatches   = 0;
  int unsigned beats_sent   = 0;
  int unsigned polar_sent   = 0;
  int unsigned cart_sent    = 0;
  int unsigned beats_seen   = 0;
  int unsigned stall_cycles = 0;
  bit          in_gaps      = 1'b1;
  bit          out_gaps     = 1'b1;
  bit          hold_request = 1'b0;

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // remove the cordic gain, round half away from zero, saturate to the output range
  function automatic logic signed [WIDTH:0] gain_scaled(input longint v);
    logic [95:0] mag;
    logic [95:0] prod;
    longint      r;
    mag  = 96'((v >= 0) ? v : -v);
    prod = mag * CORDIC_GAIN + (96'd1 << 45);
    r    = longint'(prod >> 46);
    if (v < 0) r = -r;
    if (r > OUT_MAX) r = OUT_MAX;
    if (r < OUT_MIN) r = OUT_MIN;
    return r[WIDTH:0];
  endfunction

  // expected magnitude/angle or x/y for one operand beat
  function automatic void predict_conversion(input cpc_kind_e kind,
                                             input logic signed [WIDTH-1:0] a,
                                             input logic signed [WIDTH-1:0] b,
                                             output conv_beat_t res);
    longint      x;
    longint      y;
    longint      nx;
    longint      ny;
    longint      zr;
    logic [31:0] z;
    logic [31:0] zq;
    res.kind = kind;
    res.a    = a;
    res.b    = b;
    if (kind == KIND_TO_POLAR) begin
      if (a == 0 && b == 0) begin
        // zero vector has no direction
        res.first  = '0;
        res.second = '0;
        return;
      end
      x = longint'(a) * OPERAND_ONE;
      y = longint'(b) * OPERAND_ONE;
      z = 32'h0;
      // left half plane: turn by pi first
      if (x < 0) begin
        x = -x;
        y = -y;
        z = 32'h80000000;
      end
      for (int i = 0; i < STEPS; i++) begin
        if (y >= 0) begin
          nx = x + (y >>> i);
          ny = y - (x >>> i);
          z  = z + ARCTAN_STEP[i];
        end else begin
          nx = x - (y >>> i);
          ny = y + (x >>> i);
          z  = z - ARCTAN_STEP[i];
        end
        x = nx;
        y = ny;
      end
      zq         = z + 32'h00008000;
      res.first  = gain_scaled(x);
      res.second = (WIDTH+1)'(signed'(zq[31:16]));
    end else begin
      zr = longint'(b) * OPERAND_ONE;
      x  = longint'(a) * OPERAND_ONE;
      y  = 0;
      // fold angles beyond +-pi/2 by negating the start vector
      if (zr > QUARTER_TURN) begin
        zr = zr - HALF_TURN;
        x  = -x;
      end else if (zr < -QUARTER_TURN) begin
        zr = zr + HALF_TURN;
        x  = -x;
      end
      for (int i = 0; i < STEPS; i++) begin
        if (zr >= 0) begin
          nx = x - (y >>> i);
          ny = y + (x >>> i);
          zr = zr - longint'(ARCTAN_STEP[i]);
        end else begin
          nx = x + (y >>> i);
          ny = y - (x >>> i);
          zr = zr + longint'(ARCTAN_STEP[i]);
        end
        x = nx;
        y = ny;
      end
      res.first  = gain_scaled(x);
      res.second = gain_scaled(y);
    end
  endfunction

  // operand with extra weight on range ends and quadrant edges
  function automatic logic signed [WIDTH-1:0] pick_operand();
    logic signed [WIDTH-1:0] corners [12] = '{
      -16'sd32768, -16'sd32767, -16'sd16385, -16'sd16384, -16'sd16383, -16'sd1,
      16'sd0, 16'sd1, 16'sd16383, 16'sd16384, 16'sd16385, 16'sd32767
    };
    case ($urandom_range(0, 9))
      0:       return corners[$urandom_range(0, 11)];
      1:       return WIDTH'($urandom_range(0, 63) - 32);
      default: return WIDTH'($urandom());
    endcase
  endfunction

  // drive one operand beat and hold it until accepted
  task automatic send_vector(input cpc_kind_e kind,
                             input logic signed [WIDTH-1:0] a,
                             input logic signed [WIDTH-1:0] b);
    conv_beat_t want;
    if (in_gaps && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.kind      <= kind;
    in_ch.first_in  <= a;
    in_ch.second_in <= b;
    do @(posedge clk); while (!in_ch.ready);
    predict_conversion(kind, a, b, want);
    awaited_beats.push_back(want);
    beats_sent++;
    if (kind == KIND_TO_POLAR) polar_sent++;
    else cart_sent++;
    @(negedge clk);
  endtask

  task automatic send_random_vector();
    send_vector(cpc_kind_e'($urandom_range(0, 1)), pick_operand(), pick_operand());
  endtask

  task automatic note_mismatch(input string what, input conv_beat_t want,
                               input logic signed [WIDTH:0] got_first,
                               input logic signed [WIDTH:0] got_second);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t mismatch %s: kind %s in (%0d, %0d) expected (%0d, %0d) got (%0d, %0d)",
               $realtime, what, want.kind.name(), want.a, want.b, want.first, want.second,
               got_first, got_second);
  endtask

  // axes, range ends, zero vector, pi wrap, quadrant fold edges, negative radius
  task automatic test_directed_corners();
    send_vector(KIND_TO_POLAR, 16'sd0, 16'sd0);
    send_vector(KIND_TO_POLAR, 16'sd1, 16'sd0);
    send_vector(KIND_TO_POLAR, 16'sd0, 16'sd1);
    send_vector(KIND_TO_POLAR, -16'sd1, 16'sd0);
    send_vector(KIND_TO_POLAR, 16'sd0, -16'sd1);
    send_vector(KIND_TO_POLAR, 16'sd32767, 16'sd0);
    send_vector(KIND_TO_POLAR, -16'sd32768, 16'sd0);
    send_vector(KIND_TO_POLAR, 16'sd0, 16'sd32767);
    send_vector(KIND_TO_POLAR, 16'sd0, -16'sd32768);
    send_vector(KIND_TO_POLAR, 16'sd32767, 16'sd32767);
    send_vector(KIND_TO_POLAR, -16'sd32768, -16'sd32768);
    send_vector(KIND_TO_POLAR, -16'sd32768, 16'sd32767);
    send_vector(KIND_TO_POLAR, 16'sd5, -16'sd7);
    send_vector(KIND_TO_POLAR, -16'sd300, -16'sd400);
    send_vector(KIND_TO_CART, 16'sd32767, 16'sd0);
    send_vector(KIND_TO_CART, -16'sd32768, 16'sd0);
    send_vector(KIND_TO_CART, 16'sd1000, 16'sd16384);
    send_vector(KIND_TO_CART, 16'sd1000, 16'sd16385);
    send_vector(KIND_TO_CART, 16'sd1000, -16'sd16384);
    send_vector(KIND_TO_CART, 16'sd1000, -16'sd16385);
    send_vector(KIND_TO_CART, 16'sd32767, -16'sd32768);
    send_vector(KIND_TO_CART, 16'sd32767, 16'sd32767);
    send_vector(KIND_TO_CART, 16'sd0, 16'sd12345);
    send_vector(KIND_TO_CART, -16'sd32768, 16'sd8192);
  endtask

  // mixed random beats with idle bursts on both channels
  task automatic test_random_conversions(input int unsigned count);
    in_gaps  = 1'b1;
    out_gaps = 1'b1;
    repeat (count) send_random_vector();
  endtask

  // long receiver hold while the sender keeps offering, so the pipeline fills
  task automatic test_output_backpressure(input int unsigned count);
    in_gaps      = 1'b0;
    out_gaps     = 1'b0;
    hold_request = 1'b1;
    repeat (count) send_random_vector();
  endtask

  // full rate on both sides, no idling
  task automatic test_back_to_back(input int unsigned count);
    in_gaps  = 1'b0;
    out_gaps = 1'b0;
    repeat (count) send_random_vector();
  endtask

  // result receiver with random stall bursts and one long hold on request
  initial begin : result_sink
    int unsigned n;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else if (out_gaps && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 16);
        out_ch.ready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // compare each result beat with the oldest prediction
  always @(posedge clk) begin : result_check
    conv_beat_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      beats_seen++;
      if (awaited_beats.size() == 0) begin
        want = '{KIND_TO_POLAR, '0, '0, '0, '0};
        note_mismatch("unexpected result", want, out_ch.first_out, out_ch.second_out);
      end else begin
        want = awaited_beats.pop_front();
        if (out_ch.first_out !== want.first)
          note_mismatch("first_out", want, out_ch.first_out, out_ch.second_out);
        if (out_ch.second_out !== want.second)
          note_mismatch("second_out", want, out_ch.first_out, out_ch.second_out);
      end
    end
  end

  // watchdog on cycles with no beat moving on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no beat moved for %0d cycles", stall_cycles);
      $display("*** FAILED ***");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // main sequence
  initial begin
    in_ch.valid     = 1'b0;
    in_ch.kind      = KIND_TO_POLAR;
    in_ch.first_in  = '0;
    in_ch.second_in = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_corners();
    test_random_conversions(1060);
    test_output_backpressure(120);
    test_back_to_back(350);

    in_ch.valid <= 1'b0;
    while (awaited_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d beats: %0d to polar, %0d to cartesian; %0d results checked",
             beats_sent, polar_sent, cart_sent, beats_seen);
    $display("covered corner operands, random stall bursts, a %0d-cycle output hold",
             LONG_HOLD);
    if (mismatches == 0 && awaited_beats.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, awaited_beats.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
